>>> design/qoi_pkg.sv
// ============================================================================
// qoi_pkg
// Shared types, codes and helpers of the quaternion orientation integrator.
// ============================================================================
`default_nettype none

package qoi_pkg;

    typedef logic signed [31:0] q_t;

    typedef enum logic [1:0]
    {
        CMD_LOAD = 2'd0,
        CMD_INTG = 2'd1,
        CMD_NORM = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_PMUL,
        ST_PACC,
        ST_TMUL,
        ST_TACC,
        ST_WB,
        ST_SMUL,
        ST_SACC,
        ST_BAND,
        ST_SQRT,
        ST_DSTART,
        ST_DWAIT,
        ST_DONE
    } state_t;

    typedef enum logic
    {
        ITER_SQRT = 1'b0,
        ITER_DIV  = 1'b1
    } iter_mode_t;

    typedef struct packed
    {
        logic       start;
        iter_mode_t mode;
    } iter_cmd_t;

    typedef struct packed
    {
        logic [1:0] pi;
        logic [1:0] di;
        logic       neg;
    } term_t;

    localparam logic [5:0]  SQRT_STEPS    = 6'd32;
    localparam logic [5:0]  DIV_STEPS     = 6'd61;
    localparam logic [30:0] BAND_LOW_RST  = 31'd241591910;
    localparam logic [30:0] BAND_HIGH_RST = 31'd295279001;
    localparam q_t          ONE_Q28       = 32'sh1000_0000;
    localparam logic        ADDR_BAND_LOW = 1'b0;

    // Term of the Hamilton product for a component and its sub-term.
    function automatic term_t term_sel(input logic [1:0] comp, input logic [1:0] sub);
        term_t t;
        t = '0;
        case ({comp, sub})
            4'b0000: t = '{pi: 2'd0, di: 2'd1, neg: 1'b1};
            4'b0001: t = '{pi: 2'd1, di: 2'd2, neg: 1'b1};
            4'b0010: t = '{pi: 2'd2, di: 2'd3, neg: 1'b1};
            4'b0100: t = '{pi: 2'd0, di: 2'd0, neg: 1'b0};
            4'b0101: t = '{pi: 2'd1, di: 2'd3, neg: 1'b0};
            4'b0110: t = '{pi: 2'd2, di: 2'd2, neg: 1'b1};
            4'b1000: t = '{pi: 2'd0, di: 2'd3, neg: 1'b1};
            4'b1001: t = '{pi: 2'd1, di: 2'd0, neg: 1'b0};
            4'b1010: t = '{pi: 2'd2, di: 2'd1, neg: 1'b0};
            4'b1100: t = '{pi: 2'd0, di: 2'd2, neg: 1'b0};
            4'b1101: t = '{pi: 2'd1, di: 2'd1, neg: 1'b1};
            4'b1110: t = '{pi: 2'd2, di: 2'd0, neg: 1'b0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic sat38(input logic signed [37:0] x);
        return (x > 38'sd2147483647) || (x < -38'sd2147483648);
    endfunction

    function automatic q_t clip38(input logic signed [37:0] x);
        q_t r;
        if (x > 38'sd2147483647)
            r = 32'sh7fff_ffff;
        else if (x < -38'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/qoi_mul.sv
// ============================================================================
// qoi_mul
// Shared signed 32x32 multiplier with a registered product.
// ============================================================================
`default_nettype none

module qoi_mul
(
    input  wire logic               clk,
    input  wire qoi_pkg::q_t        a,
    input  wire qoi_pkg::q_t        b,
    output logic signed [63:0]      prod
);
    import qoi_pkg::*;

    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> design/qoi_iter.sv
// ============================================================================
// qoi_iter
// Shift-subtract unit: floor square root, two bits a cycle, or unsigned
// restoring division, one bit a cycle.
// ============================================================================
`default_nettype none

module qoi_iter
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire qoi_pkg::iter_cmd_t cmd,
    input  wire logic [63:0]        radicand,
    input  wire logic [60:0]        num,
    input  wire logic [32:0]        den,
    output logic                    busy,
    output logic [60:0]             result
);
    import qoi_pkg::*;

    iter_mode_t  mode_reg;
    logic [5:0]  cnt_reg;
    logic [34:0] rem_reg;
    logic [63:0] src_reg;
    logic [60:0] res_reg;
    logic [32:0] den_reg;

    logic [34:0] rs;
    logic [34:0] trial;
    logic        ge;

    always_comb
    begin
        if (mode_reg == ITER_SQRT)
        begin
            rs    = {rem_reg[32:0], src_reg[63:62]};
            trial = {1'b0, res_reg[31:0], 2'b01};
        end
        else
        begin
            rs    = {1'b0, rem_reg[32:0], src_reg[63]};
            trial = {2'b00, den_reg};
        end
        ge = (rs >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mode_reg <= ITER_SQRT;
        end
        else if (cmd.start)
        begin
            cnt_reg  <= (cmd.mode == ITER_SQRT) ? SQRT_STEPS : DIV_STEPS;
            mode_reg <= cmd.mode;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= '0;
            res_reg <= '0;
            den_reg <= den;
            src_reg <= (cmd.mode == ITER_SQRT) ? radicand : {num, 3'b000};
        end
        else if (cnt_reg != 6'd0)
        begin
            rem_reg <= ge ? (rs - trial) : rs;
            res_reg <= {res_reg[59:0], ge};
            src_reg <= (mode_reg == ITER_SQRT) ? {src_reg[61:0], 2'b00}
                                               : {src_reg[62:0], 1'b0};
        end
    end

    assign busy   = (cnt_reg != 6'd0);
    assign result = res_reg;

endmodule

`default_nettype wire

>>> design/quaternion_orientation_integrator_top.sv
// ============================================================================
// quaternion_orientation_integrator_top
// Orientation quaternion kept in Q3.28 with load, integrate and normalize
// commands, a shared multiplier and a shared shift-subtract unit.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// in        in_valid / in_ready    command, quat_*, vec_*, step_scale
// out       out_valid / out_ready  out_w..out_z, renormalized, saturated
// cfg       APB psel/penable       paddr 0 band low, 4 band high
//
// Integrate forms 15 products on the one multiplier. Normalize leaves the
// quaternion unchanged inside the band; outside it, it rescales with 32 root
// steps and four 61-step divides.
// One word in flight; the next word is taken while the result waits.
// Asynchronous reset sets the identity quaternion and the default band.
// ============================================================================
`default_nettype none

module quaternion_orientation_integrator_top
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     command,
    input  wire qoi_pkg::q_t    quat_w,
    input  wire qoi_pkg::q_t    quat_x,
    input  wire qoi_pkg::q_t    quat_y,
    input  wire qoi_pkg::q_t    quat_z,
    input  wire qoi_pkg::q_t    vec_x,
    input  wire qoi_pkg::q_t    vec_y,
    input  wire qoi_pkg::q_t    vec_z,
    input  wire qoi_pkg::q_t    step_scale,
    output logic                out_valid,
    input  wire logic           out_ready,
    output qoi_pkg::q_t         out_w,
    output qoi_pkg::q_t         out_x,
    output qoi_pkg::q_t         out_y,
    output qoi_pkg::q_t         out_z,
    output logic                renormalized,
    output logic                saturated,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import qoi_pkg::*;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    q_t                 q_reg [4];
    q_t                 new_reg [3];
    q_t                 p_reg [3];
    q_t                 vec_reg [3];
    q_t                 scale_reg;
    logic signed [65:0] acc_reg;
    logic [1:0]         comp_reg;
    logic [1:0]         sub_reg;
    logic [31:0]        n_reg;
    logic               sat_reg;
    logic               renorm_reg;
    logic [30:0]        band_low_reg;
    logic [30:0]        band_high_reg;
    logic               out_valid_reg;
    q_t                 out_q_reg [4];
    logic               out_renorm_reg;
    logic               out_sat_reg;

    q_t                 mul_a, mul_b;
    logic signed [63:0] prod;
    iter_cmd_t          iter_cmd;
    logic               iter_busy;
    logic [60:0]        iter_res;

    term_t              ts;
    logic signed [64:0] p_round;
    logic signed [37:0] p_wide;
    logic signed [65:0] term_val;
    logic signed [65:0] acc_sum;
    logic signed [65:0] d_round;
    logic signed [37:0] c_wide;
    logic [36:0]        sq_q28;
    logic [63:0]        rad;
    logic               outband;
    logic               rad_zero;
    logic [31:0]        mag;
    logic [60:0]        div_num;
    logic               c_neg;
    logic               q_over;
    q_t                 div_val;
    logic               in_acc;
    logic               out_free;

    qoi_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    qoi_iter u_iter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (iter_cmd),
        .radicand (rad),
        .num      (div_num),
        .den      ({n_reg, 1'b0}),
        .busy     (iter_busy),
        .result   (iter_res)
    );

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Datapath arithmetic
    always_comb
    begin
        ts       = term_sel(comp_reg, sub_reg);
        p_round  = {prod[63], prod} + 65'sd134217728;
        p_wide   = {p_round[64], p_round[64:28]};
        term_val = ts.neg ? -{{2{prod[63]}}, prod} : {{2{prod[63]}}, prod};
        acc_sum  = acc_reg + term_val;
        d_round  = acc_sum + 66'sd268435456;
        c_wide   = {{6{q_reg[comp_reg][31]}}, q_reg[comp_reg]}
                 + {d_round[65], d_round[65:29]};
        if (acc_reg[64])
        begin
            sq_q28 = 37'h10_0000_0000;
            rad    = '1;
        end
        else
        begin
            sq_q28 = {1'b0, acc_reg[63:28]} + {36'd0, acc_reg[27]};
            rad    = acc_reg[63:0];
        end
        outband  = (sq_q28 < {6'd0, band_low_reg}) || (sq_q28 > {6'd0, band_high_reg});
        rad_zero = (rad == 64'd0);
        c_neg    = q_reg[comp_reg][31];
        mag      = c_neg ? (32'd0 - q_reg[comp_reg]) : q_reg[comp_reg];
        div_num  = {mag, 29'd0} + {29'd0, n_reg};
        if (c_neg)
        begin
            q_over  = (|iter_res[60:32]) || (iter_res[31] && (|iter_res[30:0]));
            div_val = q_over ? 32'sh8000_0000 : (32'sd0 - iter_res[31:0]);
        end
        else
        begin
            q_over  = |iter_res[60:31];
            div_val = q_over ? 32'sh7fff_ffff : iter_res[31:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (cmd_t'(command))
                        CMD_INTG: state_next = ST_PMUL;
                        CMD_NORM: state_next = ST_SMUL;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_PMUL:   state_next = ST_PACC;
            ST_PACC:   state_next = (comp_reg == 2'd2) ? ST_TMUL : ST_PMUL;
            ST_TMUL:   state_next = ST_TACC;
            ST_TACC:
            begin
                if (sub_reg == 2'd2 && comp_reg == 2'd3)
                    state_next = ST_WB;
                else
                    state_next = ST_TMUL;
            end
            ST_WB:     state_next = ST_DONE;
            ST_SMUL:   state_next = ST_SACC;
            ST_SACC:   state_next = (comp_reg == 2'd3) ? ST_BAND : ST_SMUL;
            ST_BAND:   state_next = (outband && !rad_zero) ? ST_SQRT : ST_DONE;
            ST_SQRT:   state_next = iter_busy ? ST_SQRT : ST_DSTART;
            ST_DSTART: state_next = ST_DWAIT;
            ST_DWAIT:
            begin
                if (!iter_busy)
                    state_next = (comp_reg == 2'd3) ? ST_DONE : ST_DSTART;
            end
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        mul_a         = '0;
        mul_b         = '0;
        iter_cmd      = '{start: 1'b0, mode: ITER_SQRT};
        case (state_reg)
            ST_PMUL:
            begin
                mul_a = vec_reg[comp_reg];
                mul_b = scale_reg;
            end
            ST_TMUL:
            begin
                mul_a = p_reg[ts.pi];
                mul_b = q_reg[ts.di];
            end
            ST_SMUL:
            begin
                mul_a = q_reg[comp_reg];
                mul_b = q_reg[comp_reg];
            end
            ST_BAND:   iter_cmd = '{start: outband && !rad_zero, mode: ITER_SQRT};
            ST_DSTART: iter_cmd = '{start: 1'b1, mode: ITER_DIV};
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            band_low_reg  <= BAND_LOW_RST;
            band_high_reg <= BAND_HIGH_RST;
            q_reg[0]      <= ONE_Q28;
            q_reg[1]      <= '0;
            q_reg[2]      <= '0;
            q_reg[3]      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == ADDR_BAND_LOW)
                    band_low_reg <= pwdata[30:0];
                else
                    band_high_reg <= pwdata[30:0];
            end
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_IDLE && in_acc && cmd_t'(command) == CMD_LOAD)
            begin
                q_reg[0] <= quat_w;
                q_reg[1] <= quat_x;
                q_reg[2] <= quat_y;
                q_reg[3] <= quat_z;
            end
            if (state_reg == ST_WB)
            begin
                q_reg[0] <= new_reg[0];
                q_reg[1] <= new_reg[1];
                q_reg[2] <= new_reg[2];
            end
            if (state_reg == ST_TACC && sub_reg == 2'd2 && comp_reg == 2'd3)
                q_reg[3] <= clip38(c_wide);
            if (state_reg == ST_DWAIT && !iter_busy)
                q_reg[comp_reg] <= div_val;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cmd_reg    <= cmd_t'(command);
                    vec_reg[0] <= vec_x;
                    vec_reg[1] <= vec_y;
                    vec_reg[2] <= vec_z;
                    scale_reg  <= step_scale;
                    sat_reg    <= 1'b0;
                    renorm_reg <= 1'b0;
                    comp_reg   <= 2'd0;
                    sub_reg    <= 2'd0;
                    acc_reg    <= '0;
                end
            end
            ST_PACC:
            begin
                p_reg[comp_reg] <= clip38(p_wide);
                sat_reg         <= sat_reg | sat38(p_wide);
                comp_reg        <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
            end
            ST_TACC:
            begin
                if (sub_reg == 2'd2)
                begin
                    if (comp_reg != 2'd3)
                        new_reg[comp_reg] <= clip38(c_wide);
                    sat_reg  <= sat_reg | sat38(c_wide);
                    acc_reg  <= '0;
                    sub_reg  <= 2'd0;
                    comp_reg <= comp_reg + 2'd1;
                end
                else
                begin
                    acc_reg <= acc_sum;
                    sub_reg <= sub_reg + 2'd1;
                end
            end
            ST_SACC:
            begin
                acc_reg  <= acc_reg + {{2{prod[63]}}, prod};
                comp_reg <= comp_reg + 2'd1;
            end
            ST_SQRT:
            begin
                if (!iter_busy)
                begin
                    n_reg      <= iter_res[31:0];
                    renorm_reg <= 1'b1;
                end
            end
            ST_DWAIT:
            begin
                if (!iter_busy)
                begin
                    sat_reg  <= sat_reg | q_over;
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_q_reg[0]   <= q_reg[0];
                    out_q_reg[1]   <= q_reg[1];
                    out_q_reg[2]   <= q_reg[2];
                    out_q_reg[3]   <= q_reg[3];
                    out_renorm_reg <= renorm_reg;
                    out_sat_reg    <= sat_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign out_w        = out_q_reg[0];
    assign out_x        = out_q_reg[1];
    assign out_y        = out_q_reg[2];
    assign out_z        = out_q_reg[3];
    assign renormalized = out_renorm_reg;
    assign saturated    = out_sat_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == ADDR_BAND_LOW) ? {1'b0, band_low_reg}
                                                      : {1'b0, band_high_reg};

`ifndef SYNTHESIS
    a_iter_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !iter_busy)
        else $error("root/divide unit busy while idle");

    a_leave_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start work");

    a_renorm_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && renorm_reg) |-> (cmd_reg == CMD_NORM))
        else $error("rescale flag outside normalize");
`endif

endmodule

`default_nettype wire
